[hw/rtl/amdfs_pkg.sv]
package amdfs_pkg;

	// field widths
	localparam int VTX_W       = 5;
	localparam int VCNT_W      = 6;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 8;

	// parameter defaults
	localparam int MAX_VERTICES_DEF = 32;
	localparam int STACK_DEPTH_DEF  = 1024;

	localparam logic [VCNT_W-1:0] VCOUNT_RST = 6'd32;

	// opcodes on s_tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_CHECK,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic insert;
		logic start;
		logic pop;
		logic visit;
		logic push;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic start_ok;
		logic rd_unvisited;
		logic sp_zero;
		logic mask_zero;
		logic emit_ok;
		logic out_free;
	} stat_t;

endpackage

[hw/rtl/amdfs_ctrl.sv]
module amdfs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_opcode,
	output logic            s_tready,
	input  amdfs_pkg::stat_t st,
	output amdfs_pkg::cmd_t  cmd
);

	amdfs_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amdfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			amdfs_pkg::ST_IDLE: begin
				if (s_tvalid && s_opcode == amdfs_pkg::OP_SEARCH && st.start_ok) begin
					state_nxt = amdfs_pkg::ST_POP;
				end
			end
			amdfs_pkg::ST_POP: begin
				state_nxt = amdfs_pkg::ST_CHECK;
			end
			amdfs_pkg::ST_CHECK: begin
				if (!st.rd_unvisited) begin
					state_nxt = st.sp_zero ? amdfs_pkg::ST_FINISH : amdfs_pkg::ST_POP;
				end else if (st.emit_ok) begin
					state_nxt = amdfs_pkg::ST_SCAN;
				end
			end
			amdfs_pkg::ST_SCAN: begin
				if (st.mask_zero) begin
					state_nxt = st.sp_zero ? amdfs_pkg::ST_FINISH : amdfs_pkg::ST_POP;
				end
			end
			amdfs_pkg::ST_FINISH: begin
				if (st.out_free) begin
					state_nxt = amdfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = amdfs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			amdfs_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.insert = s_tvalid && s_opcode == amdfs_pkg::OP_INSERT;
				cmd.start  = s_tvalid && s_opcode == amdfs_pkg::OP_SEARCH && st.start_ok;
			end
			amdfs_pkg::ST_POP: begin
				cmd.pop = 1'b1;
			end
			amdfs_pkg::ST_CHECK: begin
				cmd.visit = st.rd_unvisited && st.emit_ok;
			end
			amdfs_pkg::ST_SCAN: begin
				cmd.push = !st.mask_zero;
			end
			amdfs_pkg::ST_FINISH: begin
				cmd.finish = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hw/rtl/amdfs_datapath.sv]
module amdfs_datapath #(
	parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF,
	parameter int STACK_DEPTH  = amdfs_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [amdfs_pkg::VCNT_W-1:0]       cfg_wdata,
	input  logic [amdfs_pkg::VTX_W-1:0]        vertex_a,
	input  logic [amdfs_pkg::VTX_W-1:0]        vertex_b,
	input  logic [amdfs_pkg::VTX_W-1:0]        start_vertex,
	input  amdfs_pkg::cmd_t                    cmd,
	output amdfs_pkg::stat_t                   st,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [amdfs_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                               m_tlast
);

	localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int NW  = amdfs_pkg::VCNT_W + 1;
	localparam logic [NW-1:0]  MAX_LIM  = NW'(MAX_VERTICES);
	localparam logic [SPW-1:0] SP_FULL  = SPW'(STACK_DEPTH);

	logic [amdfs_pkg::VCNT_W-1:0] vcount_q;
	logic [MAX_VERTICES-1:0]      adj_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]      visited_q;
	logic [MAX_VERTICES-1:0]      mask_q;
	logic [VW-1:0]                stack_mem [STACK_DEPTH];
	logic [VW-1:0]                rd_q;
	logic [SPW-1:0]               sp_q;
	logic [VW-1:0]                hold_q;
	logic                         hold_valid_q;
	logic                         out_valid_q;
	logic [VW-1:0]                out_vertex_q;
	logic                         out_last_q;

	logic [NW-1:0]           n_lim;
	logic [MAX_VERTICES-1:0] rng;
	logic [MAX_VERTICES-1:0] rd_bit;
	logic [MAX_VERTICES-1:0] push_bit;
	logic [VW-1:0]           push_idx;
	logic [SPW-1:0]          sp_dec;
	logic                    a_ok, b_ok;
	logic [VW-1:0]           a_idx, b_idx;
	logic                    out_free;

	// vertices in use, clamped to the matrix size
	assign n_lim = ({1'b0, vcount_q} > MAX_LIM) ? MAX_LIM : {1'b0, vcount_q};
	assign a_ok  = {2'b00, vertex_a} < n_lim;
	assign b_ok  = {2'b00, vertex_b} < n_lim;
	assign a_idx = VW'(vertex_a);
	assign b_idx = VW'(vertex_b);

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			rng[i] = NW'(i) < n_lim;
		end
	end

	assign rd_bit = MAX_VERTICES'(1) << rd_q;

	// highest pending neighbor goes first, so the lowest ends on top
	always_comb begin
		push_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (mask_q[i]) begin
				push_idx = VW'(i);
			end
		end
	end
	assign push_bit = MAX_VERTICES'(1) << push_idx;
	assign sp_dec   = sp_q - SPW'(1);

	assign out_free = !out_valid_q || m_tready;

	assign st.start_ok     = {2'b00, start_vertex} < n_lim;
	assign st.rd_unvisited = !visited_q[rd_q];
	assign st.sp_zero      = sp_q == '0;
	assign st.mask_zero    = mask_q == '0;
	assign st.emit_ok      = !hold_valid_q || out_free;
	assign st.out_free     = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= amdfs_pkg::VCOUNT_RST;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.insert && a_ok && b_ok) begin
			adj_q[a_idx][b_idx] <= 1'b1;
			adj_q[b_idx][a_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
		end else if (cmd.start) begin
			visited_q <= '0;
		end else if (cmd.visit) begin
			visited_q <= visited_q | rd_bit;
		end
	end

	// neighbor scan mask, snapshot taken when the vertex is visited
	always_ff @(posedge clk) begin
		if (cmd.visit) begin
			mask_q <= adj_q[rd_q] & ~visited_q & ~rd_bit & rng;
		end else if (cmd.push) begin
			mask_q <= mask_q & ~push_bit;
		end
	end

	// stack pointer; a push onto a full stack is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.start) begin
			sp_q <= SPW'(1);
		end else if (cmd.pop) begin
			sp_q <= sp_dec;
		end else if (cmd.push && sp_q != SP_FULL) begin
			sp_q <= sp_q + SPW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			stack_mem[AW'(0)] <= VW'(start_vertex);
		end else if (cmd.push && sp_q != SP_FULL) begin
			stack_mem[sp_q[AW-1:0]] <= push_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			rd_q <= stack_mem[sp_dec[AW-1:0]];
		end
	end

	// one visited vertex is held back until we know whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (cmd.start || cmd.finish) begin
			hold_valid_q <= 1'b0;
		end else if (cmd.visit) begin
			hold_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.visit) begin
			hold_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.visit && hold_valid_q) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.visit && hold_valid_q) || cmd.finish) begin
			out_vertex_q <= hold_q;
			out_last_q   <= cmd.finish;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = amdfs_pkg::M_TDATA_W'(amdfs_pkg::VTX_W'(out_vertex_q));
	assign m_tlast  = out_last_q;

endmodule

[hw/rtl/adjacency_matrix_dfs_unit.sv]
// Insert word: taken back to back while idle, no result.
// Search word: each stack pop passes through the pop and check states, each
//   newly visited vertex then scans its row pushing one neighbor per cycle,
//   and the walk closes in the finish state; output stalls hold the check
//   and finish states. The registered stack read sets the pop/check pair.
// One search runs at a time; results drain through an output register.
// Reset (arst_n low): matrix, marks, stack pointer cleared, vertex_count = 32.
module adjacency_matrix_dfs_unit #(
	parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF,
	parameter int STACK_DEPTH  = amdfs_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration: vertex_count
	input  logic                               cfg_we,
	input  logic [amdfs_pkg::VCNT_W-1:0]       cfg_wdata,
	// input words
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [amdfs_pkg::S_TDATA_W-1:0]    s_tdata,  // vertex_a[4:0], vertex_b[9:5],
	                                                      // start_vertex[14:10], zero[15]
	input  logic                               s_tuser,  // opcode: 0 insert, 1 search
	// result words
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [amdfs_pkg::M_TDATA_W-1:0]    m_tdata,  // visited_vertex[4:0], zero[7:5]
	output logic                               m_tlast   // last_of_walk
);

	amdfs_pkg::cmd_t  cmd;
	amdfs_pkg::stat_t st;

	// Controller: idle / pop / check / scan / finish. A search pushes the
	// start vertex, then pops until the stack drains, scanning each new vertex's row.
	amdfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_opcode (s_tuser),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: adjacency flops, visited marks, stack memory, scan mask,
	// one-deep hold for last-word tagging, output register.
	amdfs_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.STACK_DEPTH  (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.vertex_a     (s_tdata[4:0]),
		.vertex_b     (s_tdata[9:5]),
		.start_vertex (s_tdata[14:10]),
		.cmd          (cmd),
		.st           (st),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

	// at most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.insert, cmd.start, cmd.pop, cmd.visit, cmd.push, cmd.finish}))
		else $error("more than one datapath command");

	// a visit may only push the held vertex out when the output has room
	a_visit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.visit |-> st.emit_ok)
		else $error("visit with no room for held vertex");

	// the closing word is only written into a free output register
	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free)
		else $error("finish with output register busy");

	// once a search starts, no new input word is taken the next cycle
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !s_tready)
		else $error("input accepted during a search");

endmodule

[bench/adjacency_matrix_dfs_unit_test.sv]
`timescale 1ns / 100ps

module adjacency_matrix_dfs_unit_test;

	// Worst search plus stalls, with margin after the last result.
	localparam int DRAIN_CYCLES = 3300;
	localparam int STACK_LIMIT  = amdfs_pkg::STACK_DEPTH_DEF;

	typedef struct {
		logic [amdfs_pkg::VTX_W-1:0] vertex;
		logic                        last;
	} visit_t;

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [amdfs_pkg::VCNT_W-1:0]    cfg_wdata = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	// vertex_a[4:0], vertex_b[9:5], start[14:10], 0[15]
	logic [amdfs_pkg::S_TDATA_W-1:0] s_tdata   = '0;
	logic                            s_tuser   = amdfs_pkg::OP_INSERT;  // opcode
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [amdfs_pkg::M_TDATA_W-1:0] m_tdata;          // visited_vertex[4:0], 0[7:5]
	logic                            m_tlast;          // last_of_walk

	adjacency_matrix_dfs_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Shadow of the block: adjacency matrix plus the vertex_count register.
	logic [amdfs_pkg::MAX_VERTICES_DEF-1:0] adj_rows [amdfs_pkg::MAX_VERTICES_DEF];
	logic [amdfs_pkg::VCNT_W-1:0]           cur_vertex_count = amdfs_pkg::VCOUNT_RST;
	visit_t                                 visit_q[$];   // visits still owed by the block
	int                                     mismatch_count = 0;
	bit                                     steady = 1'b0; // 1: neither side idles

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hang guard, far above the slowest legal run.
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Counts above the matrix size act as the full size.
	function automatic int unsigned live_vertices();
		return (cur_vertex_count > amdfs_pkg::MAX_VERTICES_DEF) ?
			amdfs_pkg::MAX_VERTICES_DEF : cur_vertex_count;
	endfunction

	function automatic void graph_insert(input logic [amdfs_pkg::VTX_W-1:0] va,
			input logic [amdfs_pkg::VTX_W-1:0] vb);
		int unsigned n;
		n = live_vertices();
		// edges with an end outside the live range are dropped
		if (va < n && vb < n) begin
			adj_rows[va][vb] = 1'b1;
			adj_rows[vb][va] = 1'b1;
		end
	endfunction

	// Iterative DFS: pop, skip if seen, else emit/mark and push unseen neighbors
	// high to low so the lowest index pops next. Queues the visit order.
	function automatic void predict_walk(input logic [amdfs_pkg::VTX_W-1:0] start);
		int unsigned                            n;
		logic [amdfs_pkg::VTX_W-1:0]            pending[$];
		logic [amdfs_pkg::VTX_W-1:0]            u;
		logic [amdfs_pkg::MAX_VERTICES_DEF-1:0] seen;
		visit_t                                 walk[$];
		visit_t                                 item;
		n = live_vertices();
		if (start >= n)
			return;
		seen = '0;
		pending.push_back(start);
		while (pending.size() > 0) begin
			u = pending.pop_back();
			if (seen[u])
				continue;
			seen[u] = 1'b1;
			item.vertex = u;
			item.last   = 1'b0;
			walk.push_back(item);
			for (int w = int'(n) - 1; w >= 0; w--) begin
				// edges beyond a shrunk count stay stored but are not followed
				if (adj_rows[u][w] && !seen[w] && pending.size() < STACK_LIMIT)
					pending.push_back(w[amdfs_pkg::VTX_W-1:0]);
			end
		end
		walk[walk.size()-1].last = 1'b1;
		foreach (walk[i])
			visit_q.push_back(walk[i]);
	endfunction

	// Receiver side: random back-pressure unless in a steady stretch.
	always @(posedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
	end

	// Result checker: every accepted word against the oldest owed visit.
	always @(posedge clk) begin
		visit_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (visit_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%t unexpected word: vertex %0d last %0b", $realtime,
						m_tdata[amdfs_pkg::VTX_W-1:0], m_tlast);
			end else begin
				want = visit_q.pop_front();
				if (m_tdata[amdfs_pkg::VTX_W-1:0] !== want.vertex || m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%t word mismatch: exp vertex %0d last %0b, got vertex %0d last %0b",
							$realtime, want.vertex, want.last,
							m_tdata[amdfs_pkg::VTX_W-1:0], m_tlast);
				end
			end
		end
	end

	// Sends one word (random gap first unless steady), updates the shadow once it is taken.
	// tvalid stays high on return; settle() or a gap in the next call lowers it.
	task automatic send_word(input logic op, input logic [amdfs_pkg::VTX_W-1:0] va,
			input logic [amdfs_pkg::VTX_W-1:0] vb, input logic [amdfs_pkg::VTX_W-1:0] vs);
		int unsigned gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 14)
				gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, vs, vb, va};
		do @(posedge clk); while (!s_tready);
		if (op == amdfs_pkg::OP_INSERT)
			graph_insert(va, vb);
		else
			predict_walk(vs);
	endtask

	// unused fields carry random bits
	task automatic insert_edge(input logic [amdfs_pkg::VTX_W-1:0] va,
			input logic [amdfs_pkg::VTX_W-1:0] vb);
		send_word(amdfs_pkg::OP_INSERT, va, vb, amdfs_pkg::VTX_W'($urandom_range(31)));
	endtask

	task automatic search_from(input logic [amdfs_pkg::VTX_W-1:0] vs);
		send_word(amdfs_pkg::OP_SEARCH, amdfs_pkg::VTX_W'($urandom_range(31)),
			amdfs_pkg::VTX_W'($urandom_range(31)), vs);
	endtask

	// Idle: owed visits all in, then time for a search that emits nothing.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (visit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_vertex_count(input logic [amdfs_pkg::VCNT_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_vertex_count = value;
	endtask

	// mostly live vertices, some anywhere in the 5-bit range
	function automatic logic [amdfs_pkg::VTX_W-1:0] pick_vertex();
		int unsigned n;
		n = live_vertices();
		if (n == 0 || $urandom_range(9) == 0)
			return amdfs_pkg::VTX_W'($urandom_range(31));
		return amdfs_pkg::VTX_W'($urandom_range(n - 1));
	endfunction

	// ---- directed tests ----

	// reset count of 32: corner vertices, self loop, isolated starts
	task automatic test_edge_extremes();
		insert_edge(5'd0, 5'd31);
		insert_edge(5'd31, 5'd30);
		insert_edge(5'd0, 5'd1);
		insert_edge(5'd5, 5'd5);
		search_from(5'd0);
		search_from(5'd31);
		search_from(5'd5);
		search_from(5'd17);
	endtask

	// edges beyond the count are kept but not followed; inserts beyond it dropped
	task automatic test_shrunk_count();
		set_vertex_count(6'd8);
		insert_edge(5'd7, 5'd3);
		insert_edge(5'd8, 5'd2);
		insert_edge(5'd2, 5'd31);
		search_from(5'd0);
		search_from(5'd7);
		search_from(5'd8);
		search_from(5'd31);
	endtask

	// count of zero: nothing stored, nothing walked
	task automatic test_zero_count();
		set_vertex_count(6'd0);
		insert_edge(5'd0, 5'd0);
		search_from(5'd0);
		search_from(5'd31);
	endtask

	task automatic test_single_vertex();
		set_vertex_count(6'd1);
		insert_edge(5'd0, 5'd1);
		search_from(5'd0);
	endtask

	// 63 acts as 32; edge to vertex 31 followed again
	task automatic test_count_above_limit();
		set_vertex_count(6'd63);
		insert_edge(5'd31, 5'd16);
		search_from(5'd16);
		search_from(5'd30);
	endtask

	// ---- random traffic ----

	task automatic random_traffic(input int unsigned n_items);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < 65)
				insert_edge(pick_vertex(), pick_vertex());
			else
				search_from(pick_vertex());
		end
	endtask

	task automatic test_random_full();
		set_vertex_count(6'd32);
		random_traffic(40);
	endtask

	// no idling on either side during the random traffic of this phase
	task automatic test_random_steady();
		set_vertex_count(amdfs_pkg::VCNT_W'($urandom_range(2, 31)));
		steady = 1'b1;
		random_traffic(30);
		settle();
		steady = 1'b0;
	endtask

	task automatic test_random_oversize();
		set_vertex_count(amdfs_pkg::VCNT_W'($urandom_range(33, 63)));
		random_traffic(30);
	endtask

	initial begin
		foreach (adj_rows[i])
			adj_rows[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_extremes();
		test_shrunk_count();
		test_zero_count();
		test_single_vertex();
		test_count_above_limit();
		test_random_full();
		test_random_steady();
		test_random_oversize();

		settle();
		if (mismatch_count == 0 && visit_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
